FILE: sv/qrc_pkg.sv
// ----------------------------------------------------------------------------
// qrc_pkg
// Shared widths, types and tables for the quad rotation unit.
// ----------------------------------------------------------------------------
package qrc_pkg;

  // Field formats
  localparam int COORD_W      = 20;
  localparam int ANGLE_W      = 16;
  localparam int TRIG_FRAC    = 15;
  localparam int CORNERS      = 4;

  // CORDIC working format
  localparam int TURN_W       = 32;
  localparam int WORK_FRAC    = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = WORK_FRAC + 4;

  // Derived datapath widths
  localparam int SUM_W  = COORD_W + 2;
  localparam int DIFF_W = COORD_W + 3;
  localparam int TRIG_W = TRIG_FRAC + 2;
  localparam int PROD_W = DIFF_W + TRIG_W;
  localparam int ACC_W  = PROD_W + 2;

  // Pipeline: input, CORDIC steps, trig finish, product, sum, output
  localparam int N_STG = CORDIC_STEPS + 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;
  typedef logic signed [CW-1:0]      cord_t;

  // Centroid sums and corner offsets, in quarter coordinate steps
  typedef struct packed {
    sum_t                 sx;
    sum_t                 sy;
    diff_t [CORNERS-1:0]  dx;
    diff_t [CORNERS-1:0]  dy;
  } geom_t;

  // Gain-compensated start vector, Q30
  localparam cord_t X_INIT = CW'(652032874);

  // Arctangent of 2^-i in units of 2^-32 turn
  localparam cord_t ATAN_TAB [CORDIC_STEPS] = '{
    CW'(536870912), CW'(316933406), CW'(167458907), CW'(85004756),
    CW'(42667331),  CW'(21354465),  CW'(10679838),  CW'(5340245),
    CW'(2670163),   CW'(1335087),   CW'(667544),    CW'(333772),
    CW'(166886),    CW'(83443),     CW'(41722),     CW'(20861),
    CW'(10430),     CW'(5215),      CW'(2608),      CW'(1304),
    CW'(652),       CW'(326),       CW'(163),       CW'(81),
    CW'(41),        CW'(20),        CW'(10),        CW'(5),
    CW'(3),         CW'(1)
  };

endpackage

FILE: sv/qrc_if.sv
// ----------------------------------------------------------------------------
// qrc_in_if / qrc_out_if
// Valid/ready channels carrying one quad per item.
// ----------------------------------------------------------------------------
interface qrc_in_if;
  import qrc_pkg::*;

  logic               valid;
  logic               ready;
  coord_t             p1_x;
  coord_t             p1_y;
  coord_t             p2_x;
  coord_t             p2_y;
  coord_t             p3_x;
  coord_t             p3_y;
  coord_t             p4_x;
  coord_t             p4_y;
  logic [ANGLE_W-1:0] turn_angle;

  modport source (
    output valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y, turn_angle,
    input  ready
  );
  modport sink (
    input  valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y, turn_angle,
    output ready
  );
endinterface

interface qrc_out_if;
  import qrc_pkg::*;

  logic   valid;
  logic   ready;
  coord_t r1_x;
  coord_t r1_y;
  coord_t r2_x;
  coord_t r2_y;
  coord_t r3_x;
  coord_t r3_y;
  coord_t r4_x;
  coord_t r4_y;

  modport source (
    output valid, r1_x, r1_y, r2_x, r2_y, r3_x, r3_y, r4_x, r4_y,
    input  ready
  );
  modport sink (
    input  valid, r1_x, r1_y, r2_x, r2_y, r3_x, r3_y, r4_x, r4_y,
    output ready
  );
endinterface

FILE: sv/qrc_cordic.sv
// ----------------------------------------------------------------------------
// qrc_cordic
// Pipelined rotation-mode CORDIC, one step per stage, then rounding,
// clamping and quadrant folding into cosine and sine.
// ----------------------------------------------------------------------------
module qrc_cordic (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qrc_pkg::TURN_W-1:0]  turn,
  output qrc_pkg::trig_t              cs,
  output qrc_pkg::trig_t              sn
);
  import qrc_pkg::*;

  localparam int    LAST    = CORDIC_STEPS - 1;
  localparam int    SHIFT   = WORK_FRAC - TRIG_FRAC;
  localparam cord_t ONE     = cord_t'(1) <<< TRIG_FRAC;
  localparam cord_t NEG_ONE = -ONE;
  localparam cord_t HALF    = cord_t'(1) <<< (SHIFT - 1);

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  cord_t      x_r [CORDIC_STEPS];
  cord_t      y_r [CORDIC_STEPS];
  cord_t      z_r [CORDIC_STEPS];
  logic [1:0] q_r [CORDIC_STEPS];

  cord_t      xr, yr, c_val, s_val;
  trig_t      c_t, s_t;
  trig_t      cs_r, sn_r, cs_nxt, sn_nxt;

  // One micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cord_t      xi, yi, zi;
    logic [1:0] qi;

    if (i == 0) begin : g_first
      assign xi = X_INIT;
      assign yi = '0;
      assign zi = CW'(turn[WORK_FRAC-1:0]);
      assign qi = turn[TURN_W-1 -: 2];
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign qi = q_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[CW-1]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ATAN_TAB[i];
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ATAN_TAB[i];
        end
        q_r[i] <= qi;
      end
    end
  end

  // Round to the output fraction and clamp to +/- one
  always_comb begin
    xr = (x_r[LAST] + HALF) >>> SHIFT;
    yr = (y_r[LAST] + HALF) >>> SHIFT;
    c_val = (xr > ONE) ? ONE : ((xr < NEG_ONE) ? NEG_ONE : xr);
    s_val = (yr > ONE) ? ONE : ((yr < NEG_ONE) ? NEG_ONE : yr);
    c_t = TRIG_W'(c_val);
    s_t = TRIG_W'(s_val);
  end

  // Fold the quadrant back in
  always_comb begin
    case (q_r[LAST])
      QUAD_II: begin
        cs_nxt = -s_t;
        sn_nxt = c_t;
      end
      QUAD_III: begin
        cs_nxt = -c_t;
        sn_nxt = -s_t;
      end
      QUAD_IV: begin
        cs_nxt = s_t;
        sn_nxt = -c_t;
      end
      QUAD_I: begin
        cs_nxt = c_t;
        sn_nxt = s_t;
      end
      default: begin
        cs_nxt = c_t;
        sn_nxt = s_t;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= cs_nxt;
      sn_r <= sn_nxt;
    end
  end

  assign cs = cs_r;
  assign sn = sn_r;

endmodule

FILE: sv/qrc_lane.sv
// ----------------------------------------------------------------------------
// qrc_lane
// Rotates one corner about the centroid: four products, sum with the
// centroid offset, round to nearest and saturate. Three stages.
// ----------------------------------------------------------------------------
module qrc_lane (
  input  logic            clk,
  input  logic            en,
  input  qrc_pkg::diff_t  dx,
  input  qrc_pkg::diff_t  dy,
  input  qrc_pkg::sum_t   sx,
  input  qrc_pkg::sum_t   sy,
  input  qrc_pkg::trig_t  cs,
  input  qrc_pkg::trig_t  sn,
  output qrc_pkg::coord_t rx,
  output qrc_pkg::coord_t ry
);
  import qrc_pkg::*;

  localparam int SHR_W = ACC_W - TRIG_FRAC - 2;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [SHR_W-1:0]  shr_t;

  localparam acc_t RND  = acc_t'(1) <<< (TRIG_FRAC + 1);
  localparam shr_t CMAX = {{(SHR_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam shr_t CMIN = {{(SHR_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  function automatic coord_t sat(input shr_t v);
    coord_t res;
    if (v > CMAX) begin
      res = COORD_W'(CMAX);
    end else if (v < CMIN) begin
      res = COORD_W'(CMIN);
    end else begin
      res = COORD_W'(v);
    end
    return res;
  endfunction

  prod_t  xc_r, ys_r, xs_r, yc_r;
  sum_t   sx_r, sy_r;
  acc_t   accx_r, accy_r, accx_nxt, accy_nxt;
  shr_t   vx, vy;
  coord_t rx_r, ry_r;

  // Products
  always_ff @(posedge clk) begin
    if (en) begin
      xc_r <= PROD_W'(dx * cs);
      ys_r <= PROD_W'(dy * sn);
      xs_r <= PROD_W'(dx * sn);
      yc_r <= PROD_W'(dy * cs);
      sx_r <= sx;
      sy_r <= sy;
    end
  end

  // Combine with the centroid and the rounding half step
  always_comb begin
    accx_nxt = ACC_W'(xc_r) - ACC_W'(ys_r) + (ACC_W'(sx_r) <<< TRIG_FRAC) + RND;
    accy_nxt = ACC_W'(xs_r) + ACC_W'(yc_r) + (ACC_W'(sy_r) <<< TRIG_FRAC) + RND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      accx_r <= accx_nxt;
      accy_r <= accy_nxt;
    end
  end

  // Drop the fraction and saturate
  always_comb begin
    vx = SHR_W'(accx_r >>> (TRIG_FRAC + 2));
    vy = SHR_W'(accy_r >>> (TRIG_FRAC + 2));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r <= sat(vx);
      ry_r <= sat(vy);
    end
  end

  assign rx = rx_r;
  assign ry = ry_r;

endmodule

FILE: sv/quad_rotate_about_centroid_unit.sv
// ----------------------------------------------------------------------------
// quad_rotate_about_centroid_unit
// Rotates the four corners of a quad about its centroid by a binary angle.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    p1..p4 x/y (Q16.4), turn_angle (16 b)
//  out_ch    out   valid/ready    r1..r4 x/y (Q16.4, saturated)
//
//  One item per cycle while results are taken; each accepted item passes
//  through the input stage, the 30-stage CORDIC, then the trig, product, sum
//  and output stages. The pipeline advances as a whole whenever the output
//  register is empty or being taken; in_ch.ready follows that condition.
//  Reset (rst_n low, synchronous) clears all stage valid bits.
// ----------------------------------------------------------------------------
module quad_rotate_about_centroid_unit (
  input  logic     clk,
  input  logic     rst_n,
  qrc_in_if.sink   in_ch,
  qrc_out_if.source out_ch
);
  import qrc_pkg::*;

  logic                       en;
  logic [N_STG-1:0]           valid_r, valid_nxt;
  coord_t [CORNERS-1:0]       px_r, py_r;
  logic [ANGLE_W-1:0]         ang_r;
  logic [TURN_W-1:0]          turn;
  sum_t                       sx, sy;
  geom_t                      geom_nxt;
  geom_t                      geom_r [CORDIC_STEPS+1];
  trig_t                      cs, sn;
  coord_t [CORNERS-1:0]       rx, ry;

  // Advance the whole pipeline unless a finished result is held
  assign en          = !valid_r[N_STG-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign valid_nxt   = {valid_r[N_STG-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0] <= in_ch.p1_x;
      py_r[0] <= in_ch.p1_y;
      px_r[1] <= in_ch.p2_x;
      py_r[1] <= in_ch.p2_y;
      px_r[2] <= in_ch.p3_x;
      py_r[2] <= in_ch.p3_y;
      px_r[3] <= in_ch.p4_x;
      py_r[3] <= in_ch.p4_y;
      ang_r   <= in_ch.turn_angle;
    end
  end

  // Centroid sums and corner offsets from it, in quarter steps
  always_comb begin
    sx = '0;
    sy = '0;
    for (int k = 0; k < CORNERS; k++) begin
      sx = sx + SUM_W'(px_r[k]);
      sy = sy + SUM_W'(py_r[k]);
    end
    geom_nxt.sx = sx;
    geom_nxt.sy = sy;
    for (int k = 0; k < CORNERS; k++) begin
      geom_nxt.dx[k] = (DIFF_W'(px_r[k]) <<< 2) - DIFF_W'(sx);
      geom_nxt.dy[k] = (DIFF_W'(py_r[k]) <<< 2) - DIFF_W'(sy);
    end
  end

  // Hold geometry alongside the CORDIC stages
  always_ff @(posedge clk) begin
    if (en) begin
      geom_r[0] <= geom_nxt;
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        geom_r[k] <= geom_r[k-1];
      end
    end
  end

  assign turn = {ang_r, {(TURN_W-ANGLE_W){1'b0}}};

  qrc_cordic u_cordic (
    .clk  (clk),
    .en   (en),
    .turn (turn),
    .cs   (cs),
    .sn   (sn)
  );

  // One rotation lane per corner
  for (genvar k = 0; k < CORNERS; k++) begin : g_lane
    qrc_lane u_lane (
      .clk (clk),
      .en  (en),
      .dx  (geom_r[CORDIC_STEPS].dx[k]),
      .dy  (geom_r[CORDIC_STEPS].dy[k]),
      .sx  (geom_r[CORDIC_STEPS].sx),
      .sy  (geom_r[CORDIC_STEPS].sy),
      .cs  (cs),
      .sn  (sn),
      .rx  (rx[k]),
      .ry  (ry[k])
    );
  end

  // Gather the lanes into the result item
  assign out_ch.valid = valid_r[N_STG-1];
  assign out_ch.r1_x  = rx[0];
  assign out_ch.r1_y  = ry[0];
  assign out_ch.r2_x  = rx[1];
  assign out_ch.r2_y  = ry[1];
  assign out_ch.r3_x  = rx[2];
  assign out_ch.r3_y  = ry[2];
  assign out_ch.r4_x  = rx[3];
  assign out_ch.r4_y  = ry[3];

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quad rotation unit. A CORDIC-based predictor
// computes each rotated quad, and a scoreboard matches every result, corner by
// corner, against the oldest pending prediction. Stimulus is a directed set of
// corner cases followed by random quads under changing backpressure.
// ----------------------------------------------------------------------------
module tb;
  import qrc_pkg::*;

  // Pipeline depth plus margin
  localparam int PIPE_DRAIN    = N_STG + 8;
  localparam int WATCHDOG_MAX  = 3000;
  localparam int LONG_STALL    = 300;
  localparam int LONG_STALL_AT = 650;
  localparam int RANDOM_PER_PHASE = 277;

  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));
  localparam longint TRIG_ONE  = longint'(1) << TRIG_FRAC;
  localparam longint CORDIC_X0 = 652032874;

  // Arctangent of 2^-i in 2^-32 turn
  localparam longint ARCTAN_TURN [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  typedef enum logic [1:0] {
    TURN_Q0, TURN_Q1, TURN_Q2, TURN_Q3
  } quadrant_e;

  typedef struct packed {
    coord_t [CORNERS-1:0] x;
    coord_t [CORNERS-1:0] y;
  } corners_t;

  typedef struct packed {
    corners_t           pts;
    logic [ANGLE_W-1:0] angle;
  } quad_t;

  function automatic coord_t clip_coord(longint v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each rotated quad and checks results in order
  // --------------------------------------------------------------------------
  class rotated_quad_checker;
    corners_t    pending_rotations[$];
    int unsigned failures;
    int unsigned checked;
    int unsigned ties;
    int unsigned clipped;

    function new();
      failures = 0;
      checked  = 0;
      ties     = 0;
      clipped  = 0;
    endfunction

    // Cosine and sine of a binary angle, TRIG_FRAC fraction bits
    function void sin_cos(input logic [ANGLE_W-1:0] ang, output longint cs,
                          output longint sn);
      logic [TURN_W-1:0] turn;
      longint x, y, z, xs, ys, c, s;
      turn = {ang, {(TURN_W - ANGLE_W){1'b0}}};
      z = longint'(turn[TURN_W-3:0]);
      x = CORDIC_X0;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ARCTAN_TURN[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ARCTAN_TURN[i];
        end
      end
      c = (x + (longint'(1) << (WORK_FRAC - TRIG_FRAC - 1))) >>> (WORK_FRAC - TRIG_FRAC);
      s = (y + (longint'(1) << (WORK_FRAC - TRIG_FRAC - 1))) >>> (WORK_FRAC - TRIG_FRAC);
      if (c > TRIG_ONE) c = TRIG_ONE;
      if (c < -TRIG_ONE) c = -TRIG_ONE;
      if (s > TRIG_ONE) s = TRIG_ONE;
      if (s < -TRIG_ONE) s = -TRIG_ONE;
      case (quadrant_e'(turn[TURN_W-1:TURN_W-2]))
        TURN_Q1: begin cs = -s; sn = c;  end
        TURN_Q2: begin cs = -c; sn = -s; end
        TURN_Q3: begin cs = s;  sn = -c; end
        default: begin cs = c;  sn = s;  end
      endcase
    endfunction

    // Round a scaled sum to the nearest step, half way upward, and saturate
    function coord_t round_clip(longint acc);
      longint v;
      if ((acc & ((longint'(1) << (TRIG_FRAC + 2)) - 1)) == (longint'(1) << (TRIG_FRAC + 1)))
        ties++;
      v = (acc + (longint'(1) << (TRIG_FRAC + 1))) >>> (TRIG_FRAC + 2);
      if (v > COORD_MAX || v < COORD_MIN) clipped++;
      return clip_coord(v);
    endfunction

    function corners_t rotate_about_centroid(quad_t q);
      corners_t r;
      longint sx, sy, dx, dy, cs, sn;
      sx = 0;
      sy = 0;
      for (int k = 0; k < CORNERS; k++) begin
        sx += longint'($signed(q.pts.x[k]));
        sy += longint'($signed(q.pts.y[k]));
      end
      sin_cos(q.angle, cs, sn);
      for (int k = 0; k < CORNERS; k++) begin
        dx = 4 * longint'($signed(q.pts.x[k])) - sx;
        dy = 4 * longint'($signed(q.pts.y[k])) - sy;
        r.x[k] = round_clip(dx * cs - dy * sn + sx * TRIG_ONE);
        r.y[k] = round_clip(dx * sn + dy * cs + sy * TRIG_ONE);
      end
      return r;
    endfunction

    function void note_quad(quad_t q);
      pending_rotations.push_back(rotate_about_centroid(q));
    endfunction

    function void report(string what, longint want, longint got);
      failures++;
      if (failures <= 10)
        $display("%0t MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    function void check_rotated(corners_t got);
      corners_t want;
      if (pending_rotations.size() == 0) begin
        report("unexpected result r1_x", 0, longint'($signed(got.x[0])));
        return;
      end
      want = pending_rotations.pop_front();
      checked++;
      for (int k = 0; k < CORNERS; k++) begin
        if (got.x[k] !== want.x[k])
          report($sformatf("r%0d_x", k + 1), longint'($signed(want.x[k])),
                 longint'($signed(got.x[k])));
        if (got.y[k] !== want.y[k])
          report($sformatf("r%0d_y", k + 1), longint'($signed(want.y[k])),
                 longint'($signed(got.y[k])));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the unit
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  qrc_in_if  in_ch();
  qrc_out_if out_ch();

  quad_rotate_about_centroid_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rotated_quad_checker sb = new();

  int unsigned send_gap_pct;
  int unsigned take_gap_pct;
  int unsigned quads_taken     = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned stall_left      = 0;
  bit          long_stall_done = 1'b0;
  int unsigned directed_count;

  // Observe both channels; trip the watchdog on a long quiet stretch
  always @(posedge clk) begin
    quad_t    q;
    corners_t r;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      q.pts.x = {in_ch.p4_x, in_ch.p3_x, in_ch.p2_x, in_ch.p1_x};
      q.pts.y = {in_ch.p4_y, in_ch.p3_y, in_ch.p2_y, in_ch.p1_y};
      q.angle = in_ch.turn_angle;
      sb.note_quad(q);
      quads_taken++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.x = {out_ch.r4_x, out_ch.r3_x, out_ch.r2_x, out_ch.r1_x};
      r.y = {out_ch.r4_y, out_ch.r3_y, out_ch.r2_y, out_ch.r1_y};
      sb.check_rotated(r);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               quiet_cycles, sb.pending_rotations.size());
      $display("quad_rotate_about_centroid_unit verification failed");
      $finish;
    end
  end

  // Result side: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!long_stall_done && quads_taken >= LONG_STALL_AT) begin
      out_ch.ready    <= 1'b0;
      stall_left      <= LONG_STALL - 1;
      long_stall_done <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= take_gap_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic send_quad(quad_t q);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.p1_x       <= q.pts.x[0];
    in_ch.p1_y       <= q.pts.y[0];
    in_ch.p2_x       <= q.pts.x[1];
    in_ch.p2_y       <= q.pts.y[1];
    in_ch.p3_x       <= q.pts.x[2];
    in_ch.p3_y       <= q.pts.y[2];
    in_ch.p4_x       <= q.pts.x[3];
    in_ch.p4_y       <= q.pts.y[3];
    in_ch.turn_angle <= q.angle;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_directed(longint x1, longint y1, longint x2, longint y2,
                               longint x3, longint y3, longint x4, longint y4,
                               logic [ANGLE_W-1:0] ang);
    quad_t q;
    q.pts.x = {clip_coord(x4), clip_coord(x3), clip_coord(x2), clip_coord(x1)};
    q.pts.y = {clip_coord(y4), clip_coord(y3), clip_coord(y2), clip_coord(y1)};
    q.angle = ang;
    directed_count++;
    send_quad(q);
  endtask

  function automatic longint pick_signed(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo), 0));
  endfunction

  // Mostly compact quads around a random center, plus noise, extremes and rectangles
  function automatic quad_t random_quad();
    quad_t       q;
    int unsigned mode;
    longint      cx, cy, span, w, h;
    mode = $urandom_range(99, 0);
    cx   = pick_signed(-500000, 500000);
    cy   = pick_signed(-500000, 500000);
    span = longint'(1) << $urandom_range(14, 2);
    for (int k = 0; k < CORNERS; k++) begin
      if (mode < 55) begin
        q.pts.x[k] = clip_coord(cx + pick_signed(-span, span));
        q.pts.y[k] = clip_coord(cy + pick_signed(-span, span));
      end else if (mode < 75) begin
        q.pts.x[k] = coord_t'($urandom);
        q.pts.y[k] = coord_t'($urandom);
      end else if (mode < 88) begin
        q.pts.x[k] = ($urandom_range(1, 0) != 0) ? clip_coord(COORD_MAX - pick_signed(0, 255))
                                                  : clip_coord(COORD_MIN + pick_signed(0, 255));
        q.pts.y[k] = ($urandom_range(1, 0) != 0) ? clip_coord(COORD_MAX - pick_signed(0, 255))
                                                  : clip_coord(COORD_MIN + pick_signed(0, 255));
      end
    end
    // Axis-aligned rectangle
    if (mode >= 88) begin
      w = pick_signed(1, span * 4);
      h = pick_signed(1, span * 4);
      q.pts.x = {clip_coord(cx), clip_coord(cx + w), clip_coord(cx + w), clip_coord(cx)};
      q.pts.y = {clip_coord(cy + h), clip_coord(cy + h), clip_coord(cy), clip_coord(cy)};
    end
    // Favor octant boundaries now and then
    if ($urandom_range(9, 0) < 3)
      q.angle = ANGLE_W'(($urandom_range(7, 0) << (ANGLE_W - 3)) + $urandom_range(2, 0) - 1);
    else
      q.angle = ANGLE_W'($urandom);
    return q;
  endfunction

  task automatic send_random(int unsigned count);
    repeat (count) send_quad(random_quad());
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.p1_x       <= '0;
    in_ch.p1_y       <= '0;
    in_ch.p2_x       <= '0;
    in_ch.p2_y       <= '0;
    in_ch.p3_x       <= '0;
    in_ch.p3_y       <= '0;
    in_ch.p4_x       <= '0;
    in_ch.p4_y       <= '0;
    in_ch.turn_angle <= '0;
    send_gap_pct     = 18;
    take_gap_pct     = 66;
    directed_count   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Degenerate, unit square at the quadrant angles, an eighth turn and near zero
    send_directed(0, 0, 0, 0, 0, 0, 0, 0, 16'd0);
    send_directed(0, 0, 16, 0, 16, 16, 0, 16, 16'd0);
    send_directed(0, 0, 16, 0, 16, 16, 0, 16, 16'd16384);
    send_directed(0, 0, 16, 0, 16, 16, 0, 16, 16'd32768);
    send_directed(0, 0, 16, 0, 16, 16, 0, 16, 16'd49152);
    send_directed(0, 0, 16, 0, 16, 16, 0, 16, 16'd8192);
    send_directed(0, 0, 16, 0, 16, 16, 0, 16, 16'd1);
    send_directed(0, 0, 16, 0, 16, 16, 0, 16, 16'd65535);
    send_directed(-40, 7, 100, -3, 55, 91, -12, 60, 16'd16383);
    send_directed(-40, 7, 100, -3, 55, 91, -12, 60, 16'd16385);
    // Coincident corners at both ends of the range
    send_directed(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'd12345);
    send_directed(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 16'd40000);
    // Widest spread: rotated corners leave the range and saturate
    send_directed(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                  COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 16'd8192);
    send_directed(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                  COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 16'd32768);
    send_directed(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                  COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 16'd24576);
    send_directed(COORD_MAX, 0, 0, COORD_MIN, COORD_MIN, 0, 0, COORD_MAX, 16'd57344);
    // Half turn; where a coordinate sum is odd the result lands exactly half way
    send_directed(1, 0, 0, 0, 0, 0, 0, 1, 16'd32768);
    send_directed(-3, -1, 0, 0, 2, 2, 5, -7, 16'd32768);
    send_directed(-524287, 524285, 3, -9, 77, 1, -1, 0, 16'd32768);

    // Random quads under three backpressure mixes
    send_random(RANDOM_PER_PHASE);
    send_gap_pct = 66;
    take_gap_pct = 18;
    send_random(RANDOM_PER_PHASE);
    send_gap_pct = 0;
    take_gap_pct = 0;
    send_random(RANDOM_PER_PHASE);
    in_ch.valid <= 1'b0;

    // Drain, then let any stray result surface
    while (sb.pending_rotations.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);

    $display("Covered %0d quads (%0d directed) over three backpressure mixes",
             quads_taken, directed_count);
    $display("and one %0d-cycle hold-off; checked %0d rotated quads,", LONG_STALL, sb.checked);
    $display("%0d saturated and %0d half-way coordinates, %0d errors.",
             sb.clipped, sb.ties, sb.failures);
    if (sb.failures == 0)
      $display("quad_rotate_about_centroid_unit verification clean");
    else
      $display("quad_rotate_about_centroid_unit verification failed");
    $finish;
  end

endmodule

FILE: files.f
sv/qrc_pkg.sv
sv/qrc_if.sv
sv/qrc_cordic.sv
sv/qrc_lane.sv
sv/quad_rotate_about_centroid_unit.sv
dv/tb.sv
